@@ hw/rtl/sorted_multiset_table_macros.svh @@
// Assertion macros for the checker of the sorted multiset table.
// Each macro expects a clock named aclk and an active-low reset named aresetn.
`ifndef SORTED_MULTISET_TABLE_MACROS_SVH
`define SORTED_MULTISET_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/smt_pkg.sv @@
package smt_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 16;
    localparam int TOTAL_W  = 22;
    localparam int DIST_W   = 7;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
    } entry_t;

endpackage

@@ hw/rtl/smt_store.sv @@
module smt_store #(
    parameter int DEPTH = smt_pkg::DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  smt_pkg::entry_t            wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output smt_pkg::entry_t            rd_data
);

    smt_pkg::entry_t mem [DEPTH];
    smt_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/sorted_multiset_table.sv @@
// Sorted multiset table: keeps up to DEPTH distinct signed 32-bit values in
// ascending or descending order (order_mode), each with a saturating 16-bit
// count, in a single-port-write, registered-read memory. One transaction is
// processed at a time by a sequencer around one compare unit: a scan reads
// every stored entry (a read state, then a compare state, per entry) to find
// the value and its place in the order, then an insertion or a deletion
// moves the later entries one slot at a time (a read state, then a write
// state, per moved entry). The result is registered in a done state; after
// that the sequencer returns to idle, where the next transaction is taken.
// No clearing pass is needed after reset. s_ready is high only while the
// sequencer is idle; a finished result waits in the output register while
// the next item is taken, and the sequencer holds its last state while an
// earlier result has not yet been taken.
module sorted_multiset_table #(
    parameter int DEPTH = smt_pkg::DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [smt_pkg::ACTION_W-1:0]         s_action,
    input  logic signed [smt_pkg::VALUE_W-1:0]   s_element,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [smt_pkg::STATUS_W-1:0]         m_status,
    output logic [smt_pkg::COUNT_W-1:0]          m_occurrences,
    output logic [smt_pkg::TOTAL_W-1:0]          m_total_count,
    output logic [smt_pkg::DIST_W-1:0]           m_distinct_count,
    output logic                                 m_is_empty
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W:0] DEPTH_V = (IDX_W + 1)'(DEPTH);
    localparam logic [smt_pkg::COUNT_W-1:0] COUNT_ONE = {{(smt_pkg::COUNT_W-1){1'b0}}, 1'b1};

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_DECIDE   = 4'd3;
    localparam logic [3:0] S_UP_RD    = 4'd4;
    localparam logic [3:0] S_UP_WR    = 4'd5;
    localparam logic [3:0] S_DN_RD    = 4'd6;
    localparam logic [3:0] S_DN_WR    = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0]                         state_reg, state_next;
    logic                               order_mode_reg;
    logic [smt_pkg::ACTION_W-1:0]       act_reg, act_next;
    logic signed [smt_pkg::VALUE_W-1:0] elem_reg, elem_next;
    logic [IDX_W:0]                     idx_reg, idx_next;
    logic [IDX_W:0]                     used_reg, used_next;
    logic [smt_pkg::TOTAL_W-1:0]        total_reg, total_next;
    logic                               found_reg, found_next;
    logic [IDX_W-1:0]                   slot_reg, slot_next;
    logic [smt_pkg::COUNT_W-1:0]        slot_cnt_reg, slot_cnt_next;
    logic                               pos_found_reg, pos_found_next;
    logic [IDX_W:0]                     pos_reg, pos_next;
    logic [smt_pkg::STATUS_W-1:0]       st_reg, st_next;
    logic [smt_pkg::COUNT_W-1:0]        occ_reg, occ_next;

    logic                               m_valid_reg, m_valid_next;
    logic [smt_pkg::STATUS_W-1:0]       m_status_reg, m_status_next;
    logic [smt_pkg::COUNT_W-1:0]        m_occ_reg, m_occ_next;
    logic [smt_pkg::TOTAL_W-1:0]        m_total_reg, m_total_next;
    logic [smt_pkg::DIST_W-1:0]         m_dist_reg, m_dist_next;
    logic                               m_empty_reg, m_empty_next;

    logic                               mem_we;
    logic [IDX_W-1:0]                   mem_waddr;
    smt_pkg::entry_t                    mem_wdata;
    logic [IDX_W-1:0]                   mem_raddr;
    smt_pkg::entry_t                    mem_rdata;

    logic                               precedes;
    logic [smt_pkg::COUNT_W-1:0]        dec_cnt;
    logic [31:0]                        used_wide;
    logic [IDX_W:0]                     idx_prev;
    logic [IDX_W:0]                     idx_succ;

    smt_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // The stored entry precedes or equals the element under the current order.
    assign precedes = order_mode_reg ? (mem_rdata.value >= elem_reg)
                                     : (mem_rdata.value <= elem_reg);
    assign dec_cnt   = slot_cnt_reg - 1'b1;
    assign used_wide = 32'(used_reg);
    assign idx_prev  = idx_reg - 1'b1;
    assign idx_succ  = idx_reg + 1'b1;

    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        elem_next      = elem_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        total_next     = total_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        slot_cnt_next  = slot_cnt_reg;
        pos_found_next = pos_found_reg;
        pos_next       = pos_reg;
        st_next        = st_reg;
        occ_next       = occ_reg;
        mem_we         = 1'b0;
        mem_waddr      = slot_reg;
        mem_wdata      = '{value: elem_reg, count: slot_cnt_reg};
        mem_raddr      = idx_reg[IDX_W-1:0];
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_occ_next     = m_occ_reg;
        m_total_next   = m_total_reg;
        m_dist_next    = m_dist_reg;
        m_empty_next   = m_empty_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act_next       = s_action;
                    elem_next      = s_element;
                    idx_next       = '0;
                    found_next     = 1'b0;
                    pos_found_next = 1'b0;
                    st_next        = smt_pkg::ST_DONE;
                    occ_next       = '0;
                    state_next     = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (idx_reg == used_reg) begin
                    if (!pos_found_reg) begin
                        pos_next = used_reg;
                    end
                    state_next = S_DECIDE;
                end else begin
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (!found_reg && mem_rdata.value == elem_reg) begin
                    found_next    = 1'b1;
                    slot_next     = idx_reg[IDX_W-1:0];
                    slot_cnt_next = mem_rdata.count;
                end
                if (!pos_found_reg && !precedes) begin
                    pos_found_next = 1'b1;
                    pos_next       = idx_reg;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_SCAN_RD;
            end
            S_DECIDE: begin
                state_next = S_DONE;
                case (act_reg)
                    smt_pkg::ACT_ADD: begin
                        if (found_reg) begin
                            if (slot_cnt_reg != smt_pkg::COUNT_MAX) begin
                                mem_we          = 1'b1;
                                mem_wdata.count = slot_cnt_reg + 1'b1;
                                occ_next        = slot_cnt_reg + 1'b1;
                                if (total_reg != smt_pkg::TOTAL_MAX) begin
                                    total_next = total_reg + 1'b1;
                                end
                            end else begin
                                occ_next = slot_cnt_reg;
                            end
                        end else if (used_reg >= DEPTH_V) begin
                            st_next = smt_pkg::ST_FULL;
                        end else begin
                            idx_next   = used_reg;
                            state_next = S_UP_RD;
                        end
                    end
                    smt_pkg::ACT_REMOVE: begin
                        if (!found_reg) begin
                            st_next = smt_pkg::ST_NOT_FOUND;
                        end else begin
                            occ_next = dec_cnt;
                            if (total_reg != '0) begin
                                total_next = total_reg - 1'b1;
                            end
                            if (dec_cnt != '0) begin
                                mem_we          = 1'b1;
                                mem_wdata.count = dec_cnt;
                            end else begin
                                idx_next   = {1'b0, slot_reg};
                                state_next = S_DN_RD;
                            end
                        end
                    end
                    default: begin
                        // Query, and the unused action code, change nothing.
                        if (!found_reg) begin
                            st_next = smt_pkg::ST_NOT_FOUND;
                        end else begin
                            occ_next = slot_cnt_reg;
                        end
                    end
                endcase
            end
            S_UP_RD: begin
                if (idx_reg == pos_reg) begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg[IDX_W-1:0];
                    mem_wdata  = '{value: elem_reg, count: COUNT_ONE};
                    occ_next   = COUNT_ONE;
                    used_next  = used_reg + 1'b1;
                    if (total_reg != smt_pkg::TOTAL_MAX) begin
                        total_next = total_reg + 1'b1;
                    end
                    state_next = S_DONE;
                end else begin
                    mem_raddr  = idx_prev[IDX_W-1:0];
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[IDX_W-1:0];
                mem_wdata  = mem_rdata;
                idx_next   = idx_prev;
                state_next = S_UP_RD;
            end
            S_DN_RD: begin
                if (idx_succ >= used_reg) begin
                    used_next  = used_reg - 1'b1;
                    state_next = S_DONE;
                end else begin
                    mem_raddr  = idx_succ[IDX_W-1:0];
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[IDX_W-1:0];
                mem_wdata  = mem_rdata;
                idx_next   = idx_succ;
                state_next = S_DN_RD;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = st_reg;
                    m_occ_next    = occ_reg;
                    m_total_next  = total_reg;
                    m_dist_next   = used_wide[smt_pkg::DIST_W-1:0];
                    m_empty_next  = (used_reg == '0);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            order_mode_reg <= 1'b0;
            used_reg       <= '0;
            total_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                order_mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        elem_reg      <= elem_next;
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        slot_reg      <= slot_next;
        slot_cnt_reg  <= slot_cnt_next;
        pos_found_reg <= pos_found_next;
        pos_reg       <= pos_next;
        st_reg        <= st_next;
        occ_reg       <= occ_next;
        m_status_reg  <= m_status_next;
        m_occ_reg     <= m_occ_next;
        m_total_reg   <= m_total_next;
        m_dist_reg    <= m_dist_next;
        m_empty_reg   <= m_empty_next;
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_occurrences    = m_occ_reg;
    assign m_total_count    = m_total_reg;
    assign m_distinct_count = m_dist_reg;
    assign m_is_empty       = m_empty_reg;

endmodule

@@ hw/rtl/smt_checker.sv @@
`include "sorted_multiset_table_macros.svh"

module smt_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [smt_pkg::STATUS_W-1:0]       m_status,
    input logic [smt_pkg::COUNT_W-1:0]        m_occurrences,
    input logic [smt_pkg::DIST_W-1:0]         m_distinct_count,
    input logic                               m_is_empty
);

    // A result that has not been taken must stay offered.
    `SMT_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid,
        "result dropped before transaction")

    // A failed add, remove or query never reports a count.
    `SMT_ASSERT_SAME(a_fail_no_count, m_valid && m_status != smt_pkg::ST_DONE,
        m_occurrences == '0, "count reported on failure")

    // An add refused for a full table leaves at least one distinct value behind.
    `SMT_ASSERT_SAME(a_full_not_empty, m_valid && m_status == smt_pkg::ST_FULL,
        !m_is_empty, "full status on an empty table")

    // A successful transaction that leaves the table empty reports no count.
    `SMT_ASSERT_SAME(a_empty_no_count,
        m_valid && m_is_empty && m_status == smt_pkg::ST_DONE && m_distinct_count == '0,
        m_occurrences == '0, "count reported by an empty table")

    // A transaction on the input side is only taken while the sequencer is free.
    `SMT_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready,
        "second transaction taken while busy")

endmodule

bind sorted_multiset_table smt_checker u_smt_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_occurrences    (m_occurrences),
    .m_distinct_count (m_distinct_count),
    .m_is_empty       (m_is_empty)
);

@@ verif/tb_sorted_multiset_table.sv @@
module tb_sorted_multiset_table;

    localparam int TABLE_DEPTH = smt_pkg::DEPTH_DEFAULT;
    localparam logic [smt_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;
    localparam int POOL_SIZE = 24;
    localparam int HOLD_CYCLES = 600;
    localparam int STUCK_LIMIT = 5000;
    localparam int TAIL_CYCLES = 4 * TABLE_DEPTH + 8;
    localparam int MIX_ITEMS = 300;
    localparam int REPEAT_ADDS = 150;

    typedef struct packed {
        logic [smt_pkg::STATUS_W-1:0] status;
        logic [smt_pkg::COUNT_W-1:0]  occurrences;
        logic [smt_pkg::TOTAL_W-1:0]  total;
        logic [smt_pkg::DIST_W-1:0]   distinct;
        logic                         is_empty;
    } table_reply_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic                                cfg_wr_data = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [smt_pkg::ACTION_W-1:0]        s_action = smt_pkg::ACT_QUERY;
    logic signed [smt_pkg::VALUE_W-1:0]  s_element = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [smt_pkg::STATUS_W-1:0]        m_status;
    logic [smt_pkg::COUNT_W-1:0]         m_occurrences;
    logic [smt_pkg::TOTAL_W-1:0]         m_total_count;
    logic [smt_pkg::DIST_W-1:0]          m_distinct_count;
    logic                                m_is_empty;

    // Shadow copy of the table, advanced at each accepted transaction.
    logic signed [smt_pkg::VALUE_W-1:0]  tbl_values [TABLE_DEPTH];
    logic [smt_pkg::COUNT_W-1:0]         tbl_counts [TABLE_DEPTH];
    int                                  tbl_used = 0;
    logic [smt_pkg::TOTAL_W-1:0]         tbl_total = '0;
    logic                                tbl_descending = 1'b0;

    table_reply_t                        replies_due [$];
    logic signed [smt_pkg::VALUE_W-1:0]  value_pool [POOL_SIZE];

    int s_idle_pct = 0;
    int r_idle_pct = 0;
    int fault_count = 0;
    int stuck_cycles = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    sorted_multiset_table #(
        .DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_element(s_element),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_occurrences(m_occurrences),
        .m_total_count(m_total_count),
        .m_distinct_count(m_distinct_count),
        .m_is_empty(m_is_empty)
    );

    always #4 aclk = ~aclk;

    function automatic table_reply_t apply_table_op(
        logic [smt_pkg::ACTION_W-1:0] act,
        logic signed [smt_pkg::VALUE_W-1:0] elem);
        table_reply_t reply;
        int slot;
        int pos;
        reply = '0;
        reply.status = smt_pkg::ST_DONE;
        slot = TABLE_DEPTH;
        for (int i = 0; i < tbl_used; i++) begin
            if (slot == TABLE_DEPTH && tbl_values[i] == elem) slot = i;
        end
        case (act)
            smt_pkg::ACT_ADD: begin
                if (slot < TABLE_DEPTH) begin
                    if (tbl_counts[slot] < smt_pkg::COUNT_MAX) begin
                        tbl_counts[slot]++;
                        if (tbl_total < smt_pkg::TOTAL_MAX) tbl_total++;
                    end
                    reply.occurrences = tbl_counts[slot];
                end else if (tbl_used >= TABLE_DEPTH) begin
                    reply.status = smt_pkg::ST_FULL;
                end else begin
                    // Stored entries are never re-sorted, so the place is found
                    // under whichever order is in force now.
                    pos = 0;
                    while (pos < tbl_used && (tbl_descending ? tbl_values[pos] >= elem
                                                             : tbl_values[pos] <= elem))
                        pos++;
                    for (int i = tbl_used; i > pos; i--) begin
                        tbl_values[i] = tbl_values[i-1];
                        tbl_counts[i] = tbl_counts[i-1];
                    end
                    tbl_values[pos] = elem;
                    tbl_counts[pos] = 1;
                    tbl_used++;
                    if (tbl_total < smt_pkg::TOTAL_MAX) tbl_total++;
                    reply.occurrences = 1;
                end
            end
            smt_pkg::ACT_REMOVE: begin
                if (slot == TABLE_DEPTH) begin
                    reply.status = smt_pkg::ST_NOT_FOUND;
                end else begin
                    tbl_counts[slot]--;
                    if (tbl_total > 0) tbl_total--;
                    reply.occurrences = tbl_counts[slot];
                    if (tbl_counts[slot] == 0) begin
                        for (int i = slot; i + 1 < tbl_used; i++) begin
                            tbl_values[i] = tbl_values[i+1];
                            tbl_counts[i] = tbl_counts[i+1];
                        end
                        tbl_used--;
                    end
                end
            end
            default: begin
                // A query, and the unused action code, only read the count.
                if (slot == TABLE_DEPTH) reply.status = smt_pkg::ST_NOT_FOUND;
                else reply.occurrences = tbl_counts[slot];
            end
        endcase
        reply.total = tbl_total;
        reply.distinct = tbl_used[smt_pkg::DIST_W-1:0];
        reply.is_empty = (tbl_used == 0);
        return reply;
    endfunction

    task automatic send_item(input logic [smt_pkg::ACTION_W-1:0] act,
                             input logic signed [smt_pkg::VALUE_W-1:0] elem);
        if ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < s_idle_pct);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_element <= elem;
        do @(posedge aclk); while (!s_ready);
        replies_due.push_back(apply_table_op(act, elem));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_order_mode(input logic descending);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= descending;
        @(posedge aclk);
        tbl_descending = descending;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain_table();
        while (tbl_used > 0)
            send_item(smt_pkg::ACT_REMOVE, tbl_values[$urandom_range(tbl_used - 1)]);
        wait_drained();
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endtask

    task automatic check_reply();
        table_reply_t want;
        if (replies_due.size() == 0) begin
            $error("result with no transaction outstanding: status %0d occurrences %0d",
                   m_status, m_occurrences);
            fault_count++;
        end else begin
            want = replies_due.pop_front();
            compare_field("status", want.status, m_status);
            compare_field("occurrences", want.occurrences, m_occurrences);
            compare_field("total_count", want.total, m_total_count);
            compare_field("distinct_count", want.distinct, m_distinct_count);
            compare_field("is_empty", want.is_empty, m_is_empty);
        end
    endtask

    // Result side: checks each transaction and decides m_ready for the next edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) check_reply();
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= r_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    task automatic test_directed();
        set_order_mode(1'b0);
        send_item(smt_pkg::ACT_QUERY, 0);
        send_item(smt_pkg::ACT_REMOVE, 7);
        send_item(smt_pkg::ACT_ADD, 32'sh7FFF_FFFF);
        send_item(smt_pkg::ACT_ADD, 32'sh8000_0000);
        send_item(smt_pkg::ACT_ADD, 0);
        send_item(smt_pkg::ACT_ADD, -1);
        send_item(smt_pkg::ACT_ADD, 0);
        send_item(ACT_SPARE, -1);
        send_item(ACT_SPARE, 12);
        send_item(smt_pkg::ACT_QUERY, 0);
        send_item(smt_pkg::ACT_REMOVE, 0);
        send_item(smt_pkg::ACT_REMOVE, 0);
        send_item(smt_pkg::ACT_QUERY, 0);
        send_item(smt_pkg::ACT_REMOVE, 32'sh8000_0000);
        send_item(smt_pkg::ACT_REMOVE, 0);
        wait_drained();
        // Descending now, with the ascending entries left where they are.
        set_order_mode(1'b1);
        send_item(smt_pkg::ACT_ADD, 5);
        send_item(smt_pkg::ACT_ADD, 32'sh5555_5555);
        send_item(smt_pkg::ACT_ADD, 32'shAAAA_AAAA);
        send_item(smt_pkg::ACT_ADD, 5);
        send_item(smt_pkg::ACT_QUERY, 32'sh7FFF_FFFF);
        wait_drained();
        set_order_mode(1'b0);
        send_item(smt_pkg::ACT_ADD, 3);
        send_item(smt_pkg::ACT_QUERY, 3);
        wait_drained();
    endtask

    task automatic test_full_table();
        logic signed [smt_pkg::VALUE_W-1:0] v;
        set_order_mode(1'b1);
        while (tbl_used < TABLE_DEPTH) begin
            v = $urandom;
            send_item(smt_pkg::ACT_ADD, v);
        end
        v = $urandom;
        send_item(smt_pkg::ACT_ADD, v);
        send_item(smt_pkg::ACT_ADD, tbl_values[$urandom_range(TABLE_DEPTH - 1)]);
        send_item(smt_pkg::ACT_QUERY, tbl_values[0]);
        send_item(smt_pkg::ACT_REMOVE, tbl_values[TABLE_DEPTH - 1]);
        send_item(smt_pkg::ACT_ADD, v);
        send_item(smt_pkg::ACT_ADD, ~v);
        drain_table();
    endtask

    task automatic test_receiver_holdoff();
        logic signed [smt_pkg::VALUE_W-1:0] v;
        hold_requests <= hold_requests + 1;
        for (int n = 0; n < 40; n++) begin
            v = $urandom_range(15);
            send_item((n % 3 == 2) ? smt_pkg::ACT_QUERY : smt_pkg::ACT_ADD, v);
        end
        wait_drained();
    endtask

    task automatic test_random_mix(input int items, input int s_pct, input int r_pct,
                                   input logic descending);
        int pick;
        logic [smt_pkg::ACTION_W-1:0] act;
        logic signed [smt_pkg::VALUE_W-1:0] elem;
        wait_drained();
        s_idle_pct = s_pct;
        r_idle_pct = r_pct;
        set_order_mode(descending);
        value_pool[0] = 32'sh7FFF_FFFF;
        value_pool[1] = 32'sh8000_0000;
        value_pool[2] = 0;
        value_pool[3] = -1;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = (i % 2) ? $urandom : $signed($urandom_range(64)) - 32;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) act = smt_pkg::ACT_ADD;
            else if (pick < 75) act = smt_pkg::ACT_REMOVE;
            else if (pick < 93) act = smt_pkg::ACT_QUERY;
            else act = ACT_SPARE;
            pick = $urandom_range(9);
            if (pick < 6) elem = value_pool[$urandom_range(POOL_SIZE - 1)];
            else if (pick < 8 && tbl_used > 0) elem = tbl_values[$urandom_range(tbl_used - 1)];
            else elem = $urandom;
            send_item(act, elem);
        end
        wait_drained();
    endtask

    // One value alone in the table, so each transaction is quick.
    task automatic test_repeated_value();
        logic signed [smt_pkg::VALUE_W-1:0] v;
        drain_table();
        v = $urandom;
        repeat (REPEAT_ADDS) send_item(smt_pkg::ACT_ADD, v);
        send_item(smt_pkg::ACT_QUERY, v);
        send_item(smt_pkg::ACT_REMOVE, v);
        send_item(smt_pkg::ACT_ADD, v);
        send_item(smt_pkg::ACT_ADD, ~v);
        send_item(smt_pkg::ACT_QUERY, ~v);
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        s_idle_pct = 20;
        r_idle_pct = 47;
        test_directed();
        test_full_table();
        test_receiver_holdoff();
        test_random_mix(MIX_ITEMS, 20, 47, 1'b0);
        test_random_mix(MIX_ITEMS, 47, 20, 1'b1);
        s_idle_pct = 0;
        r_idle_pct = 0;
        test_repeated_value();
        test_random_mix(MIX_ITEMS, 0, 0, 1'b0);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
